// ----- rtl/wsue_pkg.sv -----
// ----------------------------------------------------------------------------
// wsue_pkg
// Shared types and constants for the WebSocket unmask-and-echo block.
// ----------------------------------------------------------------------------
package wsue_pkg;

	// Default largest payload that the block accepts.
	localparam int unsigned BUFFER_BYTES_DEF = 4096;

	// Most server bytes that one client byte can cause.
	localparam int unsigned MAX_BURST = 10;

	// Parser phase.
	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXTLEN,
		PH_MASK,
		PH_PAYLOAD
	} phase_t;

	// Error noted at the end of the mask key, reported at the end of the frame.
	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_PROTOCOL,
		ERR_UNSUPPORTED
	} pend_err_t;

	// Opcodes.
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;

	// Close status codes.
	localparam logic [15:0] CODE_NORMAL      = 16'd1000;
	localparam logic [15:0] CODE_PROTOCOL    = 16'd1002;
	localparam logic [15:0] CODE_UNSUPPORTED = 16'd1003;
	localparam logic [15:0] CODE_TOO_BIG     = 16'd1009;

	// Header byte constants.
	localparam logic [7:0] FIN_BIT      = 8'h80;
	localparam logic [7:0] CLOSE_HDR    = 8'h88;
	localparam logic [7:0] CLOSE_LEN    = 8'h02;
	localparam logic [6:0] LEN_EXT16    = 7'd126;
	localparam logic [6:0] LEN_EXT64    = 7'd127;
	localparam logic [63:0] PING_MAX    = 64'd125;

endpackage

// ----- rtl/websocket_frame_unmask_echo.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_unmask_echo
// Parses client WebSocket frames one byte at a time, unmasks the payload and
// sends back echo, pong and close frames.
// ----------------------------------------------------------------------------
//  Channel | Signals                                  | Direction
//  input   | in_valid, in_stall, in_byte              | client bytes in
//  output  | out_valid, out_stall, out_byte,          | server bytes out
//          | run_last, close_now                      |
//
// Each client byte is parsed in the cycle of its transfer and its server bytes
// (0 to 10) are loaded into a burst register that sends one byte per cycle while
// out_stall is low. Payload bytes therefore pass at one byte per cycle while
// out_stall is low; a header or close burst holds the input while it drains.
// Reset clears the parser and empties the burst register. After a close frame
// all further input is taken and dropped.
module websocket_frame_unmask_echo
	import wsue_pkg::*;
#(
	parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       close_now
);

	localparam int unsigned PCW = $clog2(BUFFER_BYTES + 1);
	localparam int unsigned BCW = $clog2(MAX_BURST + 1);

	// Parser state.
	phase_t      phase_q, phase_d;
	logic        fin_q, fin_d;
	logic        rsv_q, rsv_d;
	logic        mask_bit_q, mask_bit_d;
	logic [3:0]  op_q, op_d;
	logic [63:0] len_q, len_d;
	logic [3:0]  lbc_q, lbc_d;
	logic [31:0] key_q, key_d;
	logic [PCW-1:0] pc_q, pc_d;
	logic [15:0] cap_q, cap_d;
	pend_err_t   pend_q, pend_d;
	logic        closed_q, closed_d;

	// Burst register.
	logic [7:0]     bytes_q [MAX_BURST];
	logic [BCW-1:0] cnt_q;
	logic           cls_q;

	logic [7:0]     bytes_d [MAX_BURST];
	logic [BCW-1:0] n;
	logic           cls_d;

	logic accept, pop;

	assign pop      = (cnt_q != '0) && !out_stall;
	assign in_stall = (cnt_q != '0) && !((cnt_q == BCW'(1)) && !out_stall);
	assign accept   = in_valid && !in_stall;

	assign out_valid = (cnt_q != '0);
	assign out_byte  = bytes_q[0];
	assign run_last  = (cnt_q == BCW'(1));
	assign close_now = cls_q && (cnt_q == BCW'(1));

	// Parse one byte and build its burst of server bytes.
	always_comb begin
		logic        len_done, mask_done, end_frame, do_close;
		logic [15:0] code;
		logic [6:0]  len7;
		logic [7:0]  ub, kb;
		logic [PCW-1:0] pc_inc;
		logic        hdr;
		logic [3:0]  hdr_op;
		phase_d    = phase_q;
		fin_d      = fin_q;
		rsv_d      = rsv_q;
		mask_bit_d = mask_bit_q;
		op_d       = op_q;
		len_d      = len_q;
		lbc_d      = lbc_q;
		key_d      = key_q;
		pc_d       = pc_q;
		cap_d      = cap_q;
		pend_d     = pend_q;
		closed_d   = closed_q;
		for (int i = 0; i < MAX_BURST; i++) begin
			bytes_d[i] = '0;
		end
		n         = '0;
		cls_d     = 1'b0;
		len_done  = 1'b0;
		mask_done = 1'b0;
		end_frame = 1'b0;
		do_close  = 1'b0;
		code      = CODE_NORMAL;
		len7      = in_byte[6:0];
		hdr       = 1'b0;
		hdr_op    = op_q;
		pc_inc    = PCW'(pc_q + 1'b1);
		unique case (pc_q[1:0])
			2'd0:    kb = key_q[31:24];
			2'd1:    kb = key_q[23:16];
			2'd2:    kb = key_q[15:8];
			default: kb = key_q[7:0];
		endcase
		ub = in_byte ^ kb;

		if (accept && !closed_q) begin
			unique case (phase_q)
				PH_HDR0: begin
					fin_d   = in_byte[7];
					rsv_d   = |in_byte[6:4];
					op_d    = in_byte[3:0];
					phase_d = PH_HDR1;
				end
				PH_HDR1: begin
					if (rsv_q) begin
						do_close = 1'b1;
						code     = CODE_PROTOCOL;
					end else begin
						mask_bit_d = in_byte[7];
						if (len7 == LEN_EXT16) begin
							len_d   = '0;
							lbc_d   = 4'd2;
							phase_d = PH_EXTLEN;
						end else if (len7 == LEN_EXT64) begin
							len_d   = '0;
							lbc_d   = 4'd8;
							phase_d = PH_EXTLEN;
						end else begin
							len_d    = 64'(len7);
							len_done = 1'b1;
						end
					end
				end
				PH_EXTLEN: begin
					len_d = {len_q[55:0], in_byte};
					if (lbc_q != '0) lbc_d = lbc_q - 1'b1;
					if (lbc_d == '0) len_done = 1'b1;
				end
				PH_MASK: begin
					key_d = {key_q[23:0], in_byte};
					if (lbc_q != '0) lbc_d = lbc_q - 1'b1;
					if (lbc_d == '0) mask_done = 1'b1;
				end
				PH_PAYLOAD: begin
					if (pend_q == ERR_NONE &&
					    (op_q == OP_TEXT || op_q == OP_BINARY || op_q == OP_PING)) begin
						bytes_d[n] = ub;
						n = n + 1'b1;
					end else if (op_q == OP_CLOSE && pc_q < PCW'(2)) begin
						cap_d = {cap_q[7:0], ub};
					end
					pc_d = pc_inc;
					if (64'(pc_inc) >= len_q) end_frame = 1'b1;
				end
				default: begin
					phase_d = PH_HDR0;
				end
			endcase

			// Length complete: check the mask bit and the size.
			if (len_done) begin
				if (!mask_bit_d) begin
					do_close = 1'b1;
					code     = CODE_PROTOCOL;
				end else if (len_d > 64'(BUFFER_BYTES)) begin
					do_close = 1'b1;
					code     = CODE_TOO_BIG;
				end else begin
					phase_d = PH_MASK;
					lbc_d   = 4'd4;
					key_d   = '0;
				end
			end

			// Mask key complete: decide the reply and send its header, if it has one.
			if (mask_done) begin
				pend_d = ERR_NONE;
				pc_d   = '0;
				cap_d  = '0;
				if (op_q == OP_TEXT || op_q == OP_BINARY) begin
					if (!fin_q) pend_d = ERR_UNSUPPORTED;
					else hdr = 1'b1;
				end else if (op_q == OP_PING) begin
					if (!fin_q || len_q > PING_MAX) pend_d = ERR_PROTOCOL;
					else begin
						hdr    = 1'b1;
						hdr_op = OP_PONG;
					end
				end else if (op_q != OP_PONG && op_q != OP_CLOSE) begin
					pend_d = ERR_PROTOCOL;
				end
				if (len_q == '0) end_frame = 1'b1;
				else phase_d = PH_PAYLOAD;
			end

			// Reply header.
			if (hdr) begin
				bytes_d[n] = FIN_BIT | {4'h0, hdr_op};
				n = n + 1'b1;
				if (len_q < 64'(LEN_EXT16)) begin
					bytes_d[n] = len_q[7:0];
					n = n + 1'b1;
				end else if (len_q <= 64'hFFFF) begin
					bytes_d[n] = {1'b0, LEN_EXT16};
					n = n + 1'b1;
					bytes_d[n] = len_q[15:8];
					n = n + 1'b1;
					bytes_d[n] = len_q[7:0];
					n = n + 1'b1;
				end else begin
					bytes_d[n] = {1'b0, LEN_EXT64};
					n = n + 1'b1;
					for (int i = 0; i < 8; i++) begin
						bytes_d[n] = len_q[56-8*i +: 8];
						n = n + 1'b1;
					end
				end
			end

			// End of frame: pick the close to send, if any.
			if (end_frame) begin
				phase_d = PH_HDR0;
				if (pend_d == ERR_PROTOCOL) begin
					do_close = 1'b1;
					code     = CODE_PROTOCOL;
				end else if (pend_d == ERR_UNSUPPORTED) begin
					do_close = 1'b1;
					code     = CODE_UNSUPPORTED;
				end else if (op_q == OP_CLOSE) begin
					do_close = 1'b1;
					code     = (len_q >= 64'd2) ? cap_d : CODE_NORMAL;
				end
			end

			// Close frame always ends the burst.
			if (do_close) begin
				bytes_d[n] = CLOSE_HDR;
				n = n + 1'b1;
				bytes_d[n] = CLOSE_LEN;
				n = n + 1'b1;
				bytes_d[n] = code[15:8];
				n = n + 1'b1;
				bytes_d[n] = code[7:0];
				n = n + 1'b1;
				cls_d    = 1'b1;
				closed_d = 1'b1;
			end
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR0;
			fin_q      <= 1'b0;
			rsv_q      <= 1'b0;
			mask_bit_q <= 1'b0;
			op_q       <= '0;
			len_q      <= '0;
			lbc_q      <= '0;
			key_q      <= '0;
			pc_q       <= '0;
			cap_q      <= '0;
			pend_q     <= ERR_NONE;
			closed_q   <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			fin_q      <= fin_d;
			rsv_q      <= rsv_d;
			mask_bit_q <= mask_bit_d;
			op_q       <= op_d;
			len_q      <= len_d;
			lbc_q      <= lbc_d;
			key_q      <= key_d;
			pc_q       <= pc_d;
			cap_q      <= cap_d;
			pend_q     <= pend_d;
			closed_q   <= closed_d;
		end
	end

	// Burst count and close flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			cls_q <= 1'b0;
		end else if (accept) begin
			cnt_q <= n;
			cls_q <= cls_d;
		end else if (pop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Burst bytes: load on a transfer, shift toward the output on a pop.
	always_ff @(posedge clk) begin
		if (accept) begin
			bytes_q <= bytes_d;
		end else if (pop) begin
			for (int i = 0; i < MAX_BURST - 1; i++) begin
				bytes_q[i] <= bytes_q[i+1];
			end
		end
	end

endmodule
